/* hdl/distance_smoothing_level_mapper_defines.svh */
// Assertion macros shared by the distance smoothing level mapper RTL.
// No dependencies; included inside module bodies that carry assertions.
`ifndef DISTANCE_SMOOTHING_LEVEL_MAPPER_DEFINES_SVH
`define DISTANCE_SMOOTHING_LEVEL_MAPPER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DSLM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define DSLM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/dslm_pkg.sv */
// Shared types, opcodes and constants for the distance smoothing level mapper.
// No dependencies.
`default_nettype none

package dslm_pkg;

  // register indexes on the configuration port
  localparam logic [1:0] CFG_SMOOTHING_WEIGHT = 2'd0;
  localparam logic [1:0] CFG_LEVEL_GAIN       = 2'd1;
  localparam logic [1:0] CFG_ZERO_RUN_LIMIT   = 2'd2;

  localparam logic [15:0] WEIGHT_RST = 16'd6554;
  localparam logic [15:0] GAIN_RST   = 16'd10240;
  localparam logic [7:0]  LIMIT_RST  = 8'd3;

  localparam logic [15:0] LN2_Q16   = 16'd45426;
  localparam logic [6:0]  LEVEL_CAP = 7'd100;

  // datapath operations
  localparam logic [3:0] OP_NOP     = 4'd0;
  localparam logic [3:0] OP_LOAD    = 4'd1;
  localparam logic [3:0] OP_MUL_A   = 4'd2;
  localparam logic [3:0] OP_MUL_B   = 4'd3;
  localparam logic [3:0] OP_AVG     = 4'd4;
  localparam logic [3:0] OP_NORM    = 4'd5;
  localparam logic [3:0] OP_SQ      = 4'd6;
  localparam logic [3:0] OP_DIFF    = 4'd7;
  localparam logic [3:0] OP_GAIN_HI = 4'd8;
  localparam logic [3:0] OP_GAIN_LO = 4'd9;
  localparam logic [3:0] OP_FIN     = 4'd10;

  typedef struct packed {
    logic [3:0] op;
  } dslm_cmd_t;

  typedef struct packed {
    logic need_blend;
  } dslm_stat_t;

  // log2 in Q.16 by repeated squaring; elaboration-time use only
  function automatic logic [20:0] log2_q16(input logic [16:0] x);
    logic [4:0]  e;
    logic [63:0] y;
    logic [15:0] frac;
    e    = 5'd0;
    frac = 16'd0;
    for (int i = 0; i < 17; i++) begin
      if (x[i]) e = 5'(i);
    end
    y = {47'd0, x} << (6'd30 - {1'b0, e});
    for (int k = 0; k < 16; k++) begin
      y    = (y * y) >> 30;
      frac = {frac[14:0], y[31]};
      if (y[31]) y = y >> 1;
    end
    return {e, frac};
  endfunction

endpackage

`default_nettype wire

/* hdl/distance_smoothing_level_mapper.sv */
// Distance smoothing level mapper: top level joining controller and datapath.
// Depends on dslm_pkg, dslm_ctrl, dslm_datapath.
//
// Usage:
//   Input channel (in_valid/in_stall, distance_cm) takes one request: a raw
//   reading in cm, 0 meaning no echo. Output channel (out_valid/out_stall)
//   returns level and smoothed_distance (Q8.8) for every request.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready;
//   write it only while the block is idle. Unknown indexes are ignored.
//   A request whose average is updated passes through the blend states; a short
//   zero run that holds the average skips them. One request is in flight at a
//   time, so a new request is taken only once the last is done. The log2 unit
//   runs a 16-step squaring loop on the shared 32x32 multiplier.
//   The result sits in an output register, so the next request is accepted
//   while it waits; a stalled receiver only holds the following result back.
//   Reset (rst, synchronous): average goes to the far limit, zero run count
//   to 0, registers to their defaults, both channels empty.
`default_nettype none

module distance_smoothing_level_mapper #(
  parameter int FAR_LIMIT_CM  = 200,
  parameter int NEAR_LIMIT_CM = 16
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [8:0]  distance_cm,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [6:0]  level,
  output logic [15:0] smoothed_distance,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [15:0] cfg_data
);
  import dslm_pkg::*;

  dslm_cmd_t  cmd;
  dslm_stat_t stat;

  assign cfg_ready = 1'b1;

  dslm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  dslm_datapath #(
    .FAR_LIMIT_CM  (FAR_LIMIT_CM),
    .NEAR_LIMIT_CM (NEAR_LIMIT_CM)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_write         (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .distance_cm       (distance_cm),
    .level             (level),
    .smoothed_distance (smoothed_distance)
  );

endmodule

`default_nettype wire

/* hdl/dslm_datapath.sv */
// Datapath: config registers, average/zero-run state, shared multiplier,
// log2 squaring loop and level scaling. Uses dslm_pkg and the defines header.
`default_nettype none

module dslm_datapath #(
  parameter int FAR_LIMIT_CM  = 200,
  parameter int NEAR_LIMIT_CM = 16
) (
  input  wire                   clk,
  input  wire                   rst,
  input  dslm_pkg::dslm_cmd_t   cmd,
  output dslm_pkg::dslm_stat_t  stat,
  input  wire                   cfg_write,
  input  wire  [1:0]            cfg_index,
  input  wire  [15:0]           cfg_data,
  input  wire  [8:0]            distance_cm,
  output logic [6:0]            level,
  output logic [15:0]           smoothed_distance
);
  import dslm_pkg::*;
  `include "distance_smoothing_level_mapper_defines.svh"

  localparam logic [8:0]  FAR_CM  = 9'(FAR_LIMIT_CM);
  localparam logic [8:0]  NEAR_CM = 9'(NEAR_LIMIT_CM);
  localparam logic [16:0] FAR_Q88 = 17'(FAR_LIMIT_CM * 256);
  localparam logic [15:0] AVG_RST = (FAR_LIMIT_CM * 256 > 65535) ? 16'hFFFF
                                                                 : 16'(FAR_LIMIT_CM * 256);
  localparam logic [20:0] LOG_FAR = log2_q16(FAR_Q88);

  logic [15:0] weight, gain;
  logic [7:0]  limit;
  logic [15:0] avg;
  logic [7:0]  zcnt;
  logic [8:0]  tgt;
  logic [52:0] acc;
  logic [30:0] y;
  logic [15:0] frac;
  logic [3:0]  lead;
  logic [15:0] plo;
  logic        lvl_zero, lvl_cap;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [31:0] sq;
  logic [7:0]  zinc;
  logic [8:0]  clamped;
  logic [3:0]  lead_next;
  logic [30:0] y_norm;
  logic [20:0] la, ldiff;
  logic [12:0] lv;

  // shared multiplier, operands picked by the current operation
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (cmd.op)
      OP_MUL_A: begin
        mul_a = {16'd0, avg};
        mul_b = {15'd0, 17'h10000 - {1'b0, weight}};
      end
      OP_MUL_B: begin
        mul_a = {15'd0, tgt, 8'd0};
        mul_b = {16'd0, weight};
      end
      OP_SQ: begin
        mul_a = {1'b0, y};
        mul_b = {1'b0, y};
      end
      OP_DIFF: begin
        mul_a = {11'd0, ldiff};
        mul_b = {16'd0, LN2_Q16};
      end
      OP_GAIN_HI: begin
        mul_a = {11'd0, acc[36:16]};
        mul_b = {16'd0, gain};
      end
      OP_GAIN_LO: begin
        mul_a = {16'd0, plo};
        mul_b = {16'd0, gain};
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;
  assign sq   = prod[61:30];

  assign zinc = (zcnt == 8'hFF) ? 8'hFF : zcnt + 8'd1;
  assign stat.need_blend = (distance_cm != 9'd0) || (zinc > limit);

  always_comb begin
    clamped = distance_cm;
    if (distance_cm < NEAR_CM) clamped = NEAR_CM;
    if (distance_cm > FAR_CM)  clamped = FAR_CM;
  end

  always_comb begin
    lead_next = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (avg[i]) lead_next = 4'(i);
    end
  end

  assign y_norm = {15'd0, avg} << (5'd30 - {1'b0, lead_next});
  assign la     = {1'b0, lead, frac};
  assign ldiff  = LOG_FAR - la;
  assign lv     = acc[52:40];

  always_ff @(posedge clk) begin
    if (rst) begin
      weight <= WEIGHT_RST;
      gain   <= GAIN_RST;
      limit  <= LIMIT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SMOOTHING_WEIGHT: weight <= cfg_data;
        CFG_LEVEL_GAIN:       gain   <= cfg_data;
        CFG_ZERO_RUN_LIMIT:   limit  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      avg  <= AVG_RST;
      zcnt <= 8'd0;
    end else begin
      case (cmd.op)
        OP_LOAD: zcnt <= (distance_cm == 9'd0) ? zinc : 8'd0;
        OP_AVG:  avg  <= (|acc[52:32]) ? 16'hFFFF : acc[31:16];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        tgt <= (distance_cm == 9'd0) ? FAR_CM : clamped;
      end
      OP_MUL_A: begin
        acc <= 53'(prod[33:0]);
      end
      OP_MUL_B: begin
        acc <= acc + 53'(prod[33:0]) + 53'd32768;
      end
      OP_NORM: begin
        y    <= y_norm;
        lead <= lead_next;
        frac <= 16'd0;
      end
      OP_SQ: begin
        frac <= {frac[14:0], sq[31]};
        y    <= sq[31] ? sq[31:1] : sq[30:0];
      end
      OP_DIFF: begin
        lvl_cap  <= (avg == 16'd0);
        lvl_zero <= ({1'b0, avg} >= FAR_Q88) || (la >= LOG_FAR);
        acc      <= 53'(prod[36:0]);
      end
      OP_GAIN_HI: begin
        plo <= acc[15:0];
        acc <= 53'(prod[36:0]);
      end
      OP_GAIN_LO: begin
        acc <= {acc[36:0], 16'd0} + 53'(prod[31:0]);
      end
      OP_FIN: begin
        smoothed_distance <= avg;
        if (lvl_cap)                        level <= LEVEL_CAP;
        else if (lvl_zero)                  level <= 7'd0;
        else if (lv > 13'(LEVEL_CAP))       level <= LEVEL_CAP;
        else                                level <= lv[6:0];
      end
      default: ;
    endcase
  end

  `DSLM_ASSERT_NEXT(fin_level_capped_a, clk, rst, cmd.op == OP_FIN, level <= LEVEL_CAP,
    "level above cap after result load")
  `DSLM_ASSERT_NEXT(norm_mantissa_a, clk, rst, (cmd.op == OP_NORM) && (avg != 16'd0),
    y[30], "mantissa not normalized")
  `DSLM_ASSERT_NEXT(sq_mantissa_a, clk, rst, (cmd.op == OP_SQ) && (avg != 16'd0),
    y[30], "mantissa left range during squaring")

endmodule

`default_nettype wire

/* hdl/dslm_ctrl.sv */
// Controller: sequences the datapath per request and owns both handshakes.
// Uses dslm_pkg and the defines header.
`default_nettype none

module dslm_ctrl (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  wire                   out_stall,
  input  dslm_pkg::dslm_stat_t  stat,
  output dslm_pkg::dslm_cmd_t   cmd
);
  import dslm_pkg::*;
  `include "distance_smoothing_level_mapper_defines.svh"

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_MUL_A   = 4'd1;
  localparam logic [3:0] S_MUL_B   = 4'd2;
  localparam logic [3:0] S_AVG     = 4'd3;
  localparam logic [3:0] S_NORM    = 4'd4;
  localparam logic [3:0] S_SQ      = 4'd5;
  localparam logic [3:0] S_DIFF    = 4'd6;
  localparam logic [3:0] S_GAIN_HI = 4'd7;
  localparam logic [3:0] S_GAIN_LO = 4'd8;
  localparam logic [3:0] S_FIN     = 4'd9;

  logic [3:0] state, state_next;
  logic [3:0] cnt;
  logic       accept, out_free, fin_load;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign fin_load = (state == S_FIN) && out_free;

  always_comb begin
    state_next = state;
    cmd.op     = OP_NOP;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.op     = OP_LOAD;
          state_next = stat.need_blend ? S_MUL_A : S_NORM;
        end
      end
      S_MUL_A: begin
        cmd.op     = OP_MUL_A;
        state_next = S_MUL_B;
      end
      S_MUL_B: begin
        cmd.op     = OP_MUL_B;
        state_next = S_AVG;
      end
      S_AVG: begin
        cmd.op     = OP_AVG;
        state_next = S_NORM;
      end
      S_NORM: begin
        cmd.op     = OP_NORM;
        state_next = S_SQ;
      end
      S_SQ: begin
        cmd.op = OP_SQ;
        if (cnt == 4'hF) state_next = S_DIFF;
      end
      S_DIFF: begin
        cmd.op     = OP_DIFF;
        state_next = S_GAIN_HI;
      end
      S_GAIN_HI: begin
        cmd.op     = OP_GAIN_HI;
        state_next = S_GAIN_LO;
      end
      S_GAIN_LO: begin
        cmd.op     = OP_GAIN_LO;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.op     = OP_FIN;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= 4'd0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= (state == S_SQ) ? cnt + 4'd1 : 4'd0;
      if (fin_load)        out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  `DSLM_ASSERT_NEXT(accept_leaves_idle_a, clk, rst, accept, state != S_IDLE,
    "request accepted but controller stayed idle")
  `DSLM_ASSERT_NEXT(sq_count_exit_a, clk, rst, (state == S_SQ) && (cnt == 4'hF),
    state == S_DIFF, "squaring loop did not end after sixteen steps")
  `DSLM_ASSERT_NEXT(fin_waits_a, clk, rst, (state == S_FIN) && out_valid && out_stall,
    (state == S_FIN) && out_valid, "pending result overwritten")

endmodule

`default_nettype wire

/* verif/distance_smoothing_level_mapper_tb.sv */
// Self-checking testbench for distance_smoothing_level_mapper: drives readings and
// register writes, predicts level and smoothed average per request, checks every result.
// Depends on dslm_pkg and the distance_smoothing_level_mapper RTL.
`default_nettype none

module distance_smoothing_level_mapper_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dslm_pkg::*;

  localparam int FAR_CM  = 200;
  localparam int NEAR_CM = 16;
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_OFF_CYCLES = 400;

  typedef struct {
    logic [6:0]  level;
    logic [15:0] smoothed;
  } level_result_t;

  // Tracks the smoothing state and the results still owed by the block.
  class distance_level_tracker;
    logic [15:0] weight;
    logic [15:0] gain;
    logic [7:0]  zero_limit;
    logic [15:0] avg;
    logic [7:0]  zero_count;
    level_result_t owed_levels[$];
    int failures;

    function new();
      weight     = WEIGHT_RST;
      gain       = GAIN_RST;
      zero_limit = LIMIT_RST;
      avg        = 16'(FAR_CM * 256);
      zero_count = 8'd0;
      failures   = 0;
    endfunction

    function int pending();
      return owed_levels.size();
    endfunction

    function void write_register(logic [1:0] idx, logic [15:0] data);
      case (idx)
        CFG_SMOOTHING_WEIGHT: weight = data;
        CFG_LEVEL_GAIN:       gain = data;
        CFG_ZERO_RUN_LIMIT:   zero_limit = data[7:0];
        default: ;
      endcase
    endfunction

    // log2 in Q.16: integer part from the top set bit, fraction by repeated squaring
    function logic [31:0] log2_fixed(logic [31:0] x);
      int unsigned msb;
      logic [63:0] y;
      logic [15:0] frac;
      msb  = 0;
      frac = 16'd0;
      while (msb < 31 && (x >> (msb + 1)) != 0) msb++;
      y = 64'(x) << (30 - msb);
      for (int i = 0; i < 16; i++) begin
        y = (y * y) >> 30;
        frac = frac << 1;
        if (y >= 64'h8000_0000) begin
          frac[0] = 1'b1;
          y = y >> 1;
        end
      end
      return {msb[15:0], frac};
    endfunction

    function void blend(int unsigned target_cm);
      logic [63:0] sum;
      sum = 64'(avg) * (64'd65536 - 64'(weight)) + 64'(target_cm) * 64'd256 * 64'(weight)
            + 64'd32768;
      sum = sum >> 16;
      avg = (sum > 64'hFFFF) ? 16'hFFFF : sum[15:0];
    endfunction

    function logic [6:0] level_for(logic [15:0] a);
      logic [31:0] lf;
      logic [31:0] la;
      logic [63:0] prod;
      if (a == 16'd0) return LEVEL_CAP;
      if (a >= FAR_CM * 256) return 7'd0;
      lf = log2_fixed(32'(FAR_CM * 256));
      la = log2_fixed(32'(a));
      if (la >= lf) return 7'd0;
      prod = (64'(lf - la) * 64'(LN2_Q16) * 64'(gain)) >> 40;
      return (prod > 64'(LEVEL_CAP)) ? LEVEL_CAP : prod[6:0];
    endfunction

    function void note_reading(logic [8:0] d);
      int unsigned target;
      level_result_t r;
      if (d == 9'd0) begin
        if (zero_count != 8'hFF) zero_count++;
        if (zero_count > zero_limit) blend(FAR_CM);
      end else begin
        zero_count = 8'd0;
        target = d;
        if (target < NEAR_CM) target = NEAR_CM;
        if (target > FAR_CM) target = FAR_CM;
        blend(target);
      end
      r.level    = level_for(avg);
      r.smoothed = avg;
      owed_levels.insert(owed_levels.size(), r);
    endfunction

    function void check_level(logic [6:0] lvl, logic [15:0] sm);
      level_result_t r;
      if (owed_levels.size() == 0) begin
        $error("unexpected result: level %0d smoothed_distance %0d", lvl, sm);
        failures++;
        return;
      end
      r = owed_levels.pop_front();
      if (lvl !== r.level) begin
        $error("level: expected %0d, actual %0d", r.level, lvl);
        failures++;
      end
      if (sm !== r.smoothed) begin
        $error("smoothed_distance: expected %0d, actual %0d", r.smoothed, sm);
        failures++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [8:0]  distance_cm = 9'd0;
  logic        out_valid;
  logic        out_stall = 1'b1;
  logic [6:0]  level;
  logic [15:0] smoothed_distance;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [15:0] cfg_data = 16'd0;

  distance_level_tracker tracker;
  int  src_idle_pct = 19;
  int  snk_idle_pct = 58;
  bit  squeeze_req = 1'b0;
  logic hold_off = 1'b0;

  distance_smoothing_level_mapper #(
    .FAR_LIMIT_CM (FAR_CM),
    .NEAR_LIMIT_CM(NEAR_CM)
  ) uut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .distance_cm      (distance_cm),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .level            (level),
    .smoothed_distance(smoothed_distance),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk) begin
    out_stall <= hold_off || ($urandom_range(0, 99) < snk_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) tracker.check_level(level, smoothed_distance);
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    wait (squeeze_req);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  task automatic send_reading(input logic [8:0] d);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    distance_cm <= d;
    do @(posedge clk); while (in_stall);
    tracker.note_reading(d);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_register(idx, data);
  endtask

  task automatic configure(input logic [15:0] w, input logic [15:0] g, input logic [7:0] lim);
    wait_idle();
    write_reg(CFG_SMOOTHING_WEIGHT, w);
    write_reg(CFG_LEVEL_GAIN, g);
    write_reg(CFG_ZERO_RUN_LIMIT, {8'd0, lim});
    // unknown index must leave every register alone
    write_reg(CFG_UNUSED, 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // bursts of zero runs and of readings spread over all ranges
  task automatic run_random(input int count, input int max_zero_run);
    int sent;
    int burst;
    int pick;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 99) < 25) begin
        burst = $urandom_range(1, max_zero_run);
        for (int i = 0; i < burst; i++) send_reading(9'd0);
      end else begin
        burst = $urandom_range(1, 6);
        for (int i = 0; i < burst; i++) begin
          pick = $urandom_range(0, 99);
          if (pick < 15)      send_reading(9'($urandom_range(1, 15)));
          else if (pick < 70) send_reading(9'($urandom_range(16, 200)));
          else if (pick < 85) send_reading(9'($urandom_range(201, 511)));
          else                send_reading(9'($urandom_range(0, 511)));
        end
      end
      sent += burst;
    end
  endtask

  initial begin
    logic [8:0] opening[$];
    int lim;
    tracker = new;
    opening = '{9'd511, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd1, 9'd15, 9'd16, 9'd17, 9'd128,
                9'd199, 9'd200, 9'd201, 9'd256, 9'd255};
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: reset settings, then the register extremes
    foreach (opening[i]) send_reading(opening[i]);
    configure(16'hFFFF, 16'hFFFF, 8'd0);
    send_reading(9'd16);
    send_reading(9'd0);
    send_reading(9'd200);
    send_reading(9'd1);
    send_reading(9'd0);
    configure(16'd0, 16'd0, 8'd255);
    send_reading(9'd5);
    send_reading(9'd0);

    configure(WEIGHT_RST, GAIN_RST, LIMIT_RST);
    squeeze_req = 1'b1;
    run_random(400, 6);

    src_idle_pct = 58;
    snk_idle_pct = 19;
    lim = $urandom_range(0, 8);
    configure(16'($urandom_range(1, 65535)), 16'($urandom_range(0, 65535)), 8'(lim));
    run_random(400, lim + 3);

    src_idle_pct = 0;
    snk_idle_pct = 0;
    // zero count saturates before it can exceed the top limit
    configure(16'($urandom_range(1, 65535)), 16'd2560, 8'd255);
    send_reading(9'd50);
    repeat (300) send_reading(9'd0);
    run_random(100, 8);

    configure(16'd32768, 16'hFFFF, 8'd0);
    run_random(400, 3);

    wait_idle();
    if (tracker.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
